>>> sv/mfd_pkg.sv
// Package: shared constants and register indexes for the minifloat to double converter.
`timescale 1ns / 1ps
package mfd_pkg;
	localparam int RawW = 64;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 10;

	typedef enum logic [CfgIdxW-1:0] {
		REG_EXP_BITS  = 2'd0,
		REG_MAN_BITS  = 2'd1,
		REG_EXP_BIAS  = 2'd2
	} cfg_reg_t;

	localparam logic [3:0] ExpBitsRst = 4'd5;
	localparam logic [5:0] ManBitsRst = 6'd10;
	localparam logic [9:0] ExpBiasRst = 10'd15;

	localparam logic [63:0] DblInf  = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] DblQnan = 64'h7FF8_0000_0000_0000;
endpackage

>>> sv/mfd_decode.sv
// Decode stage: field extraction, classification and leading-zero count of the mantissa.
`timescale 1ns / 1ps
module mfd_decode (
	input  logic [63:0] raw,
	input  logic [3:0]  eb,
	input  logic [5:0]  mb,
	output logic        oor,
	output logic        sign,
	output logic        is_special,
	output logic        is_nan,
	output logic        is_zero,
	output logic [52:0] sig,
	output logic [5:0]  msb_pos,
	output logic [11:0] ex
);
	logic [6:0]  width;
	logic [63:0] hi_mask;
	logic [10:0] emax;
	logic [51:0] man;
	logic [63:0] shifted;

	always_comb begin
		width   = 7'd1 + {3'd0, eb} + {1'b0, mb};
		hi_mask = (width >= 7'd64) ? 64'd0 : ~((64'd1 << width[5:0]) - 64'd1);
		oor     = |(raw & hi_mask);
		sign    = raw[width[5:0] - 6'd1];
		emax    = 11'((12'd1 << eb) - 12'd1);
		shifted = raw >> mb;
		ex      = {1'b0, shifted[10:0] & emax};
		man     = raw[51:0] & 52'((53'd1 << mb) - 53'd1);
		is_special = (ex[10:0] == emax);
		is_nan     = is_special && (man != 52'd0);
		is_zero    = (ex == 12'd0) && (man == 52'd0);
		sig = (ex == 12'd0) ? {1'b0, man} : ({1'b0, man} | (53'd1 << mb));
		msb_pos = 6'd0;
		for (int i = 1; i < 53; i++) begin
			if (sig[i]) msb_pos = 6'(i);
		end
	end
endmodule

>>> sv/minifloat_to_double_converter_top.sv
// Top level: configuration registers, input register, pack logic and result register.
`timescale 1ns / 1ps
// The start beat reaches the done strobe through the input register and then the result register.
// Throughput: one item per cycle; busy is never asserted.
// Reset: arst_n clears valid flags and loads format 5/10/15; no clearing pass.
// The receiver cannot stall; each result shows for exactly one cycle with done.
module minifloat_to_double_converter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] raw_bits,
	output logic        done,
	output logic [63:0] double_bits,
	output logic        out_of_range,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [mfd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [mfd_pkg::CfgDataW-1:0] cfg_data
);
	logic [3:0]  exp_bits_q;
	logic [5:0]  man_bits_q;
	logic [9:0]  exp_bias_q;
	logic        vld_s1;
	logic [63:0] raw_s1;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_bits_q <= mfd_pkg::ExpBitsRst;
			man_bits_q <= mfd_pkg::ManBitsRst;
			exp_bias_q <= mfd_pkg::ExpBiasRst;
		end else if (cfg_valid) begin
			case (cfg_index)
				mfd_pkg::REG_EXP_BITS: exp_bits_q <= cfg_data[3:0];
				mfd_pkg::REG_MAN_BITS: man_bits_q <= cfg_data[5:0];
				mfd_pkg::REG_EXP_BIAS: exp_bias_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= start;
	end
	always_ff @(posedge clk) begin
		if (start) raw_s1 <= raw_bits;
	end

	// clamp format widths
	logic [3:0] eb;
	logic [5:0] mb;
	always_comb begin
		eb = (exp_bits_q < 4'd2) ? 4'd2 : (exp_bits_q > 4'd11) ? 4'd11 : exp_bits_q;
		mb = (man_bits_q < 6'd1) ? 6'd1 : (man_bits_q > 6'd52) ? 6'd52 : man_bits_q;
	end

	logic        oor, sgn, is_special, is_nan, is_zero;
	logic [52:0] sig;
	logic [5:0]  msb_pos;
	logic [11:0] ex;

	mfd_decode u_dec (
		.raw(raw_s1), .eb(eb), .mb(mb), .oor(oor), .sign(sgn),
		.is_special(is_special), .is_nan(is_nan), .is_zero(is_zero),
		.sig(sig), .msb_pos(msb_pos), .ex(ex)
	);

	// value = sig * 2^k, k = max(ex,1) - bias - mb; unbiased e = k + msb_pos
	logic signed [13:0] k, e;
	logic [63:0] res, sh, subn;
	always_comb begin
		k = $signed({2'b0, ((ex == 12'd0) ? 12'd1 : ex)}) - $signed({4'd0, exp_bias_q})
			- $signed({8'd0, mb});
		e = k + $signed({8'd0, msb_pos});
		sh = {11'd0, sig} << (6'd52 - msb_pos);
		subn = (k < -14'sd1074) ? 64'd0 : ({11'd0, sig} << 7'(k + 14'sd1074));
		if (is_special) res = is_nan ? mfd_pkg::DblQnan : mfd_pkg::DblInf;
		else if (is_zero) res = 64'd0;
		else if (e > 14'sd1023) res = mfd_pkg::DblInf;
		else if (e >= -14'sd1022) res = {1'b0, 11'(e + 14'sd1023), sh[51:0]};
		else res = {12'd0, subn[51:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= vld_s1;
	end
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			out_of_range <= oor;
			double_bits  <= oor ? 64'd0 : {sgn, res[62:0]};
		end
	end
endmodule

>>> sim/minifloat_to_double_converter_top_tb.sv
// Testbench: minifloat to double converter, predicted results checked beat by beat.
`timescale 1ns / 1ps
module minifloat_to_double_converter_top_tb;
	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [63:0] raw_bits;
	logic done;
	logic [63:0] double_bits;
	logic out_of_range;
	logic cfg_valid;
	logic cfg_ready;
	logic [mfd_pkg::CfgIdxW-1:0] cfg_index;
	logic [mfd_pkg::CfgDataW-1:0] cfg_data;

	typedef struct packed {
		logic [63:0] dbl;
		logic        oor;
	} conv_result_t;

	conv_result_t expected_dbl_q[$];
	logic [3:0] fmt_exp_bits;
	logic [5:0] fmt_man_bits;
	logic [9:0] fmt_bias;
	int errors;
	bit allow_idle;

	minifloat_to_double_converter_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .raw_bits(raw_bits),
		.done(done), .double_bits(double_bits), .out_of_range(out_of_range),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end

	// binary64 pattern of sig * 2^k
	function automatic logic [63:0] scale_to_double(logic [63:0] sig, longint k);
		int p;
		longint e;
		p = 52;
		while (p > 0 && sig[p] == 1'b0) p--;
		e = k + p;
		if (e > 1023) return mfd_pkg::DblInf;
		if (e >= -1022)
			return {1'b0, 11'(e + 1023), 52'(sig << (52 - p))};
		if (k < -1074) return 64'd0;
		return {12'd0, 52'(sig << (k + 1074))};
	endfunction

	function automatic conv_result_t convert_minifloat(logic [63:0] raw);
		int eb, mb, width;
		longint bias;
		logic [63:0] emax, ex, man, mag;
		conv_result_t r;
		eb = fmt_exp_bits < 2 ? 2 : (fmt_exp_bits > 11 ? 11 : fmt_exp_bits);
		mb = fmt_man_bits < 1 ? 1 : (fmt_man_bits > 52 ? 52 : fmt_man_bits);
		bias = fmt_bias;
		width = 1 + eb + mb;
		r.oor = 1'b0;
		if (width < 64 && (raw >> width) != 0) begin
			r.dbl = 64'd0;
			r.oor = 1'b1;
			return r;
		end
		emax = (64'd1 << eb) - 1;
		ex = (raw >> mb) & emax;
		man = raw & ((64'd1 << mb) - 1);
		if (ex == emax)
			mag = man != 0 ? mfd_pkg::DblQnan : mfd_pkg::DblInf;
		else if (ex == 0)
			mag = man == 0 ? 64'd0 : scale_to_double(man, 1 - bias - mb);
		else
			mag = scale_to_double((64'd1 << mb) | man, longint'(ex) - bias - mb);
		r.dbl = {raw[width-1], 63'd0} | mag;
		return r;
	endfunction

	task automatic idle_gap();
		while (allow_idle && $urandom_range(99) < 34) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_value(logic [63:0] raw);
		idle_gap();
		start <= 1'b1;
		raw_bits <= raw;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_dbl_q.push_back(convert_minifloat(raw));
	endtask

	task automatic drain();
		start <= 1'b0;
		while (expected_dbl_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(mfd_pkg::cfg_reg_t idx, logic [mfd_pkg::CfgDataW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			mfd_pkg::REG_EXP_BITS: fmt_exp_bits = val[3:0];
			mfd_pkg::REG_MAN_BITS: fmt_man_bits = val[5:0];
			default: fmt_bias = val;
		endcase
	endtask

	task automatic set_format(int eb, int mb, int bias);
		drain();
		write_reg(mfd_pkg::REG_EXP_BITS, mfd_pkg::CfgDataW'(eb));
		write_reg(mfd_pkg::REG_MAN_BITS, mfd_pkg::CfgDataW'(mb));
		write_reg(mfd_pkg::REG_EXP_BIAS, mfd_pkg::CfgDataW'(bias));
	endtask

	// random pattern mostly within the format width, sometimes with stray high bits
	function automatic logic [63:0] random_pattern();
		int eb, mb, width;
		logic [63:0] v, m;
		eb = fmt_exp_bits < 2 ? 2 : (fmt_exp_bits > 11 ? 11 : fmt_exp_bits);
		mb = fmt_man_bits < 1 ? 1 : (fmt_man_bits > 52 ? 52 : fmt_man_bits);
		width = 1 + eb + mb;
		v = {$urandom, $urandom};
		m = width >= 64 ? '1 : (64'd1 << width) - 1;
		case ($urandom_range(9))
			0: return v;
			1: return v & m & ~((64'd1 << (width - 1)) - (64'd1 << mb)); // subnormal/zero
			2: return v & m | ((64'd1 << (width - 1)) - (64'd1 << mb)); // inf/nan
			default: return v & m;
		endcase
	endfunction

	task automatic test_default_format();
		send_value(64'h0000);
		send_value(64'h8000);
		send_value(64'h3C00);
		send_value(64'hBC00);
		send_value(64'h0001);
		send_value(64'h03FF);
		send_value(64'h7BFF);
		send_value(64'h7C00);
		send_value(64'hFC00);
		send_value(64'h7C01);
		send_value(64'hFE00);
		send_value(64'h1_0000);
		send_value(64'hFFFF_FFFF_FFFF_FFFF);
	endtask

	task automatic test_extreme_formats();
		set_format(11, 52, 1023);
		send_value(64'h0000_0000_0000_0001);
		send_value(64'h7FEF_FFFF_FFFF_FFFF);
		send_value(64'hFFF0_0000_0000_0000);
		send_value(64'hFFFF_FFFF_FFFF_FFFF);
		set_format(11, 52, 0); // large exponents saturate to infinity
		send_value(64'h7FE0_0000_0000_0000);
		send_value(64'h0000_0000_0000_0001);
		set_format(2, 1, 0);
		for (int i = 0; i < 16; i++) send_value(64'(i));
		set_format(0, 0, 1023); // clamped to 2/1
		send_value(64'h3);
		send_value(64'h9);
		set_format(15, 63, 512); // clamped to 11/52
		send_value(64'h8000_0000_0000_0001);
	endtask

	task automatic test_random_values();
		int fmt_eb, fmt_mb;
		for (int blk = 0; blk < 29; blk++) begin
			fmt_eb = $urandom_range(0, 15);
			fmt_mb = $urandom_range(0, 63);
			set_format(fmt_eb, fmt_mb, $urandom_range(0, 1023));
			allow_idle = (blk != 5);
			for (int i = 0; i < 50; i++) send_value(random_pattern());
		end
		allow_idle = 1'b1;
		drain();
	endtask

	always @(posedge clk) begin
		conv_result_t exp_r;
		if (arst_n && done) begin
			if (expected_dbl_q.size() == 0) begin
				$error("unexpected result beat: double_bits %h", double_bits);
				errors++;
			end else begin
				exp_r = expected_dbl_q.pop_front();
				if (double_bits !== exp_r.dbl) begin
					$error("double_bits: expected %h, actual %h", exp_r.dbl, double_bits);
					errors++;
				end
				if (out_of_range !== exp_r.oor) begin
					$error("out_of_range: expected %b, actual %b", exp_r.oor, out_of_range);
					errors++;
				end
			end
		end
	end

	initial begin
		errors = 0;
		allow_idle = 1'b1;
		arst_n = 1'b0;
		start = 1'b0;
		raw_bits = '0;
		cfg_valid = 1'b0;
		cfg_index = mfd_pkg::REG_EXP_BITS;
		cfg_data = '0;
		fmt_exp_bits = mfd_pkg::ExpBitsRst;
		fmt_man_bits = mfd_pkg::ManBitsRst;
		fmt_bias = mfd_pkg::ExpBiasRst;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_format();
		test_extreme_formats();
		test_random_values();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

>>> files.f
sv/mfd_pkg.sv
sv/mfd_decode.sv
sv/minifloat_to_double_converter_top.sv
sim/minifloat_to_double_converter_top_tb.sv
